### sv/sbr_pkg.sv
package sbr_pkg;

   // Kinds of control-transfer instruction, carried on the request tuser.
   typedef enum logic [1:0] {
      ACT_CALL = 2'd0,
      ACT_BICC = 2'd1,
      ACT_JMPL = 2'd2,
      ACT_TICC = 2'd3
   } action_type;

   // Condition field codes that the logic names directly.
   localparam logic [3:0] COND_ALWAYS = 4'd8;

   localparam logic [31:0] SEQ_STEP = 32'd8;
   localparam int unsigned TRAP_NUM_W = 7;

   localparam int unsigned REQ_TDATA_W = 176;
   localparam int unsigned RSP_TDATA_W = 112;

   // One request item, unpacked.
   typedef struct packed {
      action_type  action;
      logic [3:0]  cond;
      logic [3:0]  icc;
      logic [31:0] pc;
      logic [29:0] immediate;
      logic [31:0] rs1_value;
      logic [31:0] rs2_value;
      logic        use_immediate;
      logic        link_nonzero;
      logic        check_prediction;
      logic        predicted_taken;
      logic [31:0] predicted_target;
   } req_item_type;

   // One result item, unpacked.
   typedef struct packed {
      logic                  taken;
      logic [31:0]           next_pc;
      logic [31:0]           link_value;
      logic                  trap_raised;
      logic [TRAP_NUM_W-1:0] trap_number;
      logic                  unsupported;
      logic                  mispredict;
      logic                  btb_taken;
      logic [31:0]           btb_target;
   } rsp_item_type;

   // Integer condition test. The top bit of the condition inverts the base test.
   function automatic logic cond_holds(input logic [3:0] cond, input logic [3:0] icc);
      logic n;
      logic z;
      logic v;
      logic c;
      logic r;
      n = icc[3];
      z = icc[2];
      v = icc[1];
      c = icc[0];
      unique case (cond[2:0])
         3'd0: r = 1'b0;
         3'd1: r = z;
         3'd2: r = z | (n ^ v);
         3'd3: r = n ^ v;
         3'd4: r = c | z;
         3'd5: r = c;
         3'd6: r = n;
         default: r = v;
      endcase
      return cond[3] ? ~r : r;
   endfunction

endpackage

### sv/sparc_branch_resolve_core.sv
// Channel | Direction | Handshake            | Payload
// req     | in        | req_tvalid/req_tready | tuser: action; tdata: operands and prediction
// rsp     | out       | rsp_tvalid/rsp_tready | tdata: resolved outcome and BTB update
//
// One item is accepted per cycle while rsp_tready does not stall the result; its result is
// offered once it has passed the input register and then the result register, with no
// bubbles between items. The two register stages sit around the target adders and the
// prediction compare.
// Reset (synchronous, active high) empties both stages; there is no other state.
// A stall on rsp_tready holds the result and backs up into the input stage.
module sparc_branch_resolve_core (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // [1:0] action
   input  logic [1:0]   req_tuser,
   // [3:0] cond, [7:4] icc, [39:8] pc, [69:40] immediate, [101:70] rs1_value,
   // [133:102] rs2_value, [134] use_immediate, [135] link_nonzero,
   // [136] check_prediction, [137] predicted_taken, [169:138] predicted_target
   input  logic [sbr_pkg::REQ_TDATA_W-1:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // [0] taken, [32:1] next_pc, [64:33] link_value, [65] trap_raised,
   // [72:66] trap_number, [73] unsupported, [74] mispredict, [75] btb_taken,
   // [107:76] btb_target
   output logic [sbr_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   sbr_pkg::req_item_type req_item;
   sbr_pkg::req_item_type item_ff;
   sbr_pkg::req_item_type item_in;
   logic                  item_valid_ff;
   logic                  item_valid_in;
   sbr_pkg::rsp_item_type rsp_ff;
   sbr_pkg::rsp_item_type rsp_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic                  rsp_room;
   logic                  item_room;

   logic [31:0] op2;
   logic [31:0] seq_pc;
   logic [31:0] call_target;
   logic [31:0] bicc_target;
   logic [31:0] reg_sum;
   logic        bicc_taken;
   logic        pred_ok;
   sbr_pkg::rsp_item_type res;

   // Unpack the request item.
   always_comb begin
      req_item.action           = sbr_pkg::action_type'(req_tuser);
      req_item.cond             = req_tdata[3:0];
      req_item.icc              = req_tdata[7:4];
      req_item.pc               = req_tdata[39:8];
      req_item.immediate        = req_tdata[69:40];
      req_item.rs1_value        = req_tdata[101:70];
      req_item.rs2_value        = req_tdata[133:102];
      req_item.use_immediate    = req_tdata[134];
      req_item.link_nonzero     = req_tdata[135];
      req_item.check_prediction = req_tdata[136];
      req_item.predicted_taken  = req_tdata[137];
      req_item.predicted_target = req_tdata[169:138];
   end

   // Stage flow control: each stage moves when the one after it has room.
   assign rsp_room      = ~rsp_valid_ff | rsp_tready;
   assign item_room     = ~item_valid_ff | rsp_room;
   assign req_tready    = item_room;
   assign item_valid_in = item_room ? req_tvalid : item_valid_ff;
   assign item_in       = (item_room && req_tvalid) ? req_item : item_ff;
   assign rsp_valid_in  = rsp_room ? item_valid_ff : rsp_valid_ff;
   assign rsp_in        = (rsp_room && item_valid_ff) ? res : rsp_ff;

   // Target adders and the sequential address.
   always_comb begin
      op2         = item_ff.use_immediate ?
                    {{19{item_ff.immediate[12]}}, item_ff.immediate[12:0]} :
                    item_ff.rs2_value;
      seq_pc      = item_ff.pc + sbr_pkg::SEQ_STEP;
      call_target = item_ff.pc + {item_ff.immediate, 2'b00};
      bicc_target = item_ff.pc + {{8{item_ff.immediate[21]}}, item_ff.immediate[21:0], 2'b00};
      reg_sum     = item_ff.rs1_value + op2;
      bicc_taken  = sbr_pkg::cond_holds(item_ff.cond, item_ff.icc);
   end

   // Resolve the instruction and check the prediction.
   always_comb begin
      res = '0;
      res.next_pc = seq_pc;
      unique case (item_ff.action)
         sbr_pkg::ACT_CALL: begin
            res.taken      = 1'b1;
            res.next_pc    = call_target;
            res.link_value = item_ff.pc;
         end
         sbr_pkg::ACT_BICC: begin
            res.taken = bicc_taken;
            if (bicc_taken) begin
               res.next_pc = bicc_target;
            end
         end
         sbr_pkg::ACT_JMPL: begin
            res.taken      = 1'b1;
            res.next_pc    = reg_sum;
            res.link_value = item_ff.link_nonzero ? item_ff.pc : 32'd0;
         end
         default: begin
            if (item_ff.cond == sbr_pkg::COND_ALWAYS) begin
               res.trap_raised = 1'b1;
               res.trap_number = reg_sum[sbr_pkg::TRAP_NUM_W-1:0];
            end else begin
               res.unsupported = 1'b1;
            end
         end
      endcase

      pred_ok = (~res.taken & ~item_ff.predicted_taken) |
                (res.taken & item_ff.predicted_taken &
                 (res.next_pc == item_ff.predicted_target));
      if (item_ff.check_prediction) begin
         if (pred_ok) begin
            res.btb_taken  = item_ff.predicted_taken;
            res.btb_target = item_ff.predicted_target;
         end else begin
            res.mispredict = 1'b1;
            res.btb_taken  = (item_ff.action == sbr_pkg::ACT_JMPL) ?
                             item_ff.predicted_taken : ~item_ff.predicted_taken;
            res.btb_target = res.next_pc;
         end
      end
   end

   // Stage registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   // Pack the result item.
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0,
                        rsp_ff.btb_target,
                        rsp_ff.btb_taken,
                        rsp_ff.mispredict,
                        rsp_ff.unsupported,
                        rsp_ff.trap_number,
                        rsp_ff.trap_raised,
                        rsp_ff.link_value,
                        rsp_ff.next_pc,
                        rsp_ff.taken};

   // A trap instruction never transfers control and is either raised or unsupported.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_ff.taken && (rsp_ff.trap_raised || rsp_ff.unsupported)))
      else $error("taken result also flagged as trap");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_ff.trap_raised && rsp_ff.unsupported))
      else $error("trap raised and unsupported together");

   // A result only appears after an item has stood in the input stage.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(item_valid_ff))
      else $error("result without an item in the input stage");

   // The input stage takes nothing new while it is full and the result is stalled.
   assert property (@(posedge clock) disable iff (reset)
      (item_valid_ff && rsp_valid_ff && !rsp_tready) |=> $stable(item_ff))
      else $error("input stage overwritten during a stall");

endmodule

### tb/sv/tb.sv
module tb;

   // Cycles with work outstanding but no transfer on either channel before the run is abandoned.
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   // Length of the long receiver hold-off that backs the block up.
   localparam int unsigned HOLD_OFF_CYCLES = 80;

   // Base tests selected by the low three bits of the condition field.
   typedef enum logic [2:0] {
      TEST_NEVER,
      TEST_EQUAL,
      TEST_LESS_EQ,
      TEST_LESS,
      TEST_LESS_EQ_U,
      TEST_CARRY,
      TEST_NEGATIVE,
      TEST_OVERFLOW
   } flag_test_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [1:0]   req_tuser;
   logic [175:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [111:0] rsp_tdata;

   sbr_pkg::req_item_type transfer_on_bus = '0;
   sbr_pkg::req_item_type pending_transfers[$];
   sbr_pkg::rsp_item_type resolved_outcomes[$];

   int unsigned send_idle_pct = 0;
   int unsigned recv_stall_pct = 0;
   logic        pressure_req = 1'b0;
   logic        pressure_done = 1'b0;
   int unsigned hold_count = 0;
   int unsigned idle_cycles = 0;
   int unsigned mismatches = 0;

   sparc_branch_resolve_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Free-running clock, period of two time units.
   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // Request item packing, highest field first, cond in the lowest bits.
   assign req_tuser = transfer_on_bus.action;
   assign req_tdata = {6'b0,
                       transfer_on_bus.predicted_target,
                       transfer_on_bus.predicted_taken,
                       transfer_on_bus.check_prediction,
                       transfer_on_bus.link_nonzero,
                       transfer_on_bus.use_immediate,
                       transfer_on_bus.rs2_value,
                       transfer_on_bus.rs1_value,
                       transfer_on_bus.immediate,
                       transfer_on_bus.pc,
                       transfer_on_bus.icc,
                       transfer_on_bus.cond};

   // Evaluates a condition field against the N, Z, V and C flags.
   function automatic logic condition_met(input logic [3:0] cond, input logic [3:0] flags);
      logic base;
      case (flag_test_type'(cond[2:0]))
         TEST_NEVER:     base = 1'b0;
         TEST_EQUAL:     base = flags[2];
         TEST_LESS_EQ:   base = flags[2] || (flags[3] != flags[1]);
         TEST_LESS:      base = flags[3] != flags[1];
         TEST_LESS_EQ_U: base = flags[0] || flags[2];
         TEST_CARRY:     base = flags[0];
         TEST_NEGATIVE:  base = flags[3];
         default:        base = flags[1];
      endcase
      return cond[3] ? !base : base;
   endfunction

   // Works out the outcome of one control-transfer instruction.
   function automatic sbr_pkg::rsp_item_type resolve_transfer(input sbr_pkg::req_item_type it);
      sbr_pkg::rsp_item_type outcome;
      logic [31:0]  operand2;
      logic [31:0]  trap_sum;
      logic         correct;
      outcome = '0;
      operand2 = it.use_immediate ? {{19{it.immediate[12]}}, it.immediate[12:0]}
                                  : it.rs2_value;
      trap_sum = it.rs1_value + operand2;
      outcome.next_pc = it.pc + sbr_pkg::SEQ_STEP;
      case (it.action)
         sbr_pkg::ACT_CALL: begin
            outcome.taken = 1'b1;
            outcome.next_pc = it.pc + {it.immediate, 2'b00};
            outcome.link_value = it.pc;
         end
         sbr_pkg::ACT_BICC: begin
            outcome.taken = condition_met(it.cond, it.icc);
            if (outcome.taken) begin
               outcome.next_pc = it.pc + {{8{it.immediate[21]}}, it.immediate[21:0], 2'b00};
            end
         end
         sbr_pkg::ACT_JMPL: begin
            outcome.taken = 1'b1;
            outcome.next_pc = it.rs1_value + operand2;
            outcome.link_value = it.link_nonzero ? it.pc : 32'd0;
         end
         default: begin
            if (it.cond == sbr_pkg::COND_ALWAYS) begin
               outcome.trap_raised = 1'b1;
               outcome.trap_number = trap_sum[sbr_pkg::TRAP_NUM_W-1:0];
            end else begin
               outcome.unsupported = 1'b1;
            end
         end
      endcase
      // Prediction check and the values for the target buffer write.
      if (it.check_prediction) begin
         correct = (!outcome.taken && !it.predicted_taken) ||
                   (outcome.taken && it.predicted_taken &&
                    outcome.next_pc == it.predicted_target);
         if (correct) begin
            outcome.btb_taken = it.predicted_taken;
            outcome.btb_target = it.predicted_target;
         end else begin
            outcome.mispredict = 1'b1;
            outcome.btb_taken = (it.action == sbr_pkg::ACT_JMPL) ? it.predicted_taken
                                                                 : !it.predicted_taken;
            outcome.btb_target = outcome.next_pc;
         end
      end
      return outcome;
   endfunction

   // Random word, with the corner values drawn more often than chance.
   function automatic logic [31:0] pick_word();
      case ($urandom_range(7))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return 32'h8000_0000;
         3: return 32'h7FFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   // Random instruction; half of the predictions carry the correct target.
   function automatic sbr_pkg::req_item_type random_transfer();
      sbr_pkg::req_item_type it;
      logic [31:0]  word;
      it.action = sbr_pkg::action_type'($urandom_range(3));
      it.cond = 4'($urandom_range(15));
      if (it.action == sbr_pkg::ACT_TICC && $urandom_range(1)) begin
         it.cond = sbr_pkg::COND_ALWAYS;
      end
      it.icc = 4'($urandom_range(15));
      it.pc = pick_word();
      word = pick_word();
      it.immediate = word[29:0];
      it.rs1_value = pick_word();
      it.rs2_value = pick_word();
      it.use_immediate = 1'($urandom_range(1));
      it.link_nonzero = 1'($urandom_range(1));
      it.check_prediction = ($urandom_range(7) != 0);
      it.predicted_taken = 1'($urandom_range(1));
      it.predicted_target = pick_word();
      if ($urandom_range(1)) begin
         it.predicted_target = resolve_transfer(it).next_pc;
      end
      return it;
   endfunction

   // Queues one item; a matching prediction takes the resolved next address.
   task automatic queue_transfer(input sbr_pkg::req_item_type it, input logic matching);
      if (matching) begin
         it.predicted_target = resolve_transfer(it).next_pc;
      end
      pending_transfers.push_back(it);
   endtask

   // Waits until every queued item is accepted and every result has arrived.
   task automatic wait_drained();
      while (pending_transfers.size() != 0 || req_tvalid || resolved_outcomes.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic run_random_phase(input int unsigned count, input int unsigned send_pct,
                                   input int unsigned recv_pct);
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      repeat (count) pending_transfers.push_back(random_transfer());
      wait_drained();
   endtask

   task automatic compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] seen);
      if (want !== seen) begin
         $display("%0t: %s expected %h, got %h", $time, name, want, seen);
         mismatches++;
      end
   endtask

   // Request driver: offers the next pending item and records its outcome on acceptance.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            resolved_outcomes.push_back(resolve_transfer(transfer_on_bus));
         end
         if (!req_tvalid || req_tready) begin
            if (pending_transfers.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               transfer_on_bus <= pending_transfers.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result receiver: random stalls, and one long hold-off when pressure is requested.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_count != 0) begin
         hold_count <= hold_count - 1;
         rsp_tready <= 1'b0;
      end else if (pressure_req && !pressure_done) begin
         hold_count <= HOLD_OFF_CYCLES;
         pressure_done <= 1'b1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Result monitor: each accepted item is checked against the oldest outcome.
   always @(posedge clock) begin
      sbr_pkg::rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (resolved_outcomes.size() == 0) begin
            $display("%0t: unexpected result, expected none, got %h", $time, rsp_tdata);
            mismatches++;
         end else begin
            want = resolved_outcomes.pop_front();
            compare_field("taken", 32'(want.taken), 32'(rsp_tdata[0]));
            compare_field("next_pc", want.next_pc, rsp_tdata[32:1]);
            compare_field("link_value", want.link_value, rsp_tdata[64:33]);
            compare_field("trap_raised", 32'(want.trap_raised), 32'(rsp_tdata[65]));
            compare_field("trap_number", 32'(want.trap_number), 32'(rsp_tdata[72:66]));
            compare_field("unsupported", 32'(want.unsupported), 32'(rsp_tdata[73]));
            compare_field("mispredict", 32'(want.mispredict), 32'(rsp_tdata[74]));
            compare_field("btb_taken", 32'(want.btb_taken), 32'(rsp_tdata[75]));
            compare_field("btb_target", want.btb_target, rsp_tdata[107:76]);
         end
      end
   end

   // Watchdog: counts cycles in which work is outstanding but nothing moves.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (pending_transfers.size() == 0 && !req_tvalid && resolved_outcomes.size() == 0)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Stimulus sequence.
   initial begin
      sbr_pkg::req_item_type item;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Every condition code on a conditional branch, with a spread of flags.
      for (int code = 0; code < 16; code++) begin
         item = '0;
         item.action = sbr_pkg::ACT_BICC;
         item.cond = code[3:0];
         item.icc = code[3:0] * 4'd5;
         item.pc = 32'h0000_1000 * code;
         item.immediate = code[0] ? 30'h0020_0000 : 30'h001F_FFFF;
         item.check_prediction = 1'b1;
         item.predicted_taken = code[1];
         queue_transfer(item, code[2]);
      end

      // Call with the largest displacement, wrapping the address.
      item = '0;
      item.action = sbr_pkg::ACT_CALL;
      item.pc = 32'hFFFF_FFFC;
      item.immediate = 30'h3FFF_FFFF;
      item.check_prediction = 1'b1;
      item.predicted_taken = 1'b1;
      queue_transfer(item, 1'b1);
      item = '0;
      item.action = sbr_pkg::ACT_CALL;
      queue_transfer(item, 1'b0);

      // Jump and link: most negative and most positive simm13, and a register operand.
      item = '0;
      item.action = sbr_pkg::ACT_JMPL;
      item.use_immediate = 1'b1;
      item.immediate = 30'h0000_1000;
      item.pc = 32'h1234_5678;
      item.link_nonzero = 1'b1;
      item.check_prediction = 1'b1;
      item.predicted_taken = 1'b1;
      item.predicted_target = 32'hDEAD_BEEF;
      queue_transfer(item, 1'b0);
      item = '0;
      item.action = sbr_pkg::ACT_JMPL;
      item.use_immediate = 1'b1;
      item.immediate = 30'h0000_0FFF;
      item.rs1_value = 32'hFFFF_FFFF;
      item.check_prediction = 1'b1;
      queue_transfer(item, 1'b0);
      item = '0;
      item.action = sbr_pkg::ACT_JMPL;
      item.rs1_value = 32'hFFFF_FFFF;
      item.rs2_value = 32'hFFFF_FFFF;
      item.pc = 32'hFFFF_FFFF;
      item.link_nonzero = 1'b1;
      item.check_prediction = 1'b1;
      item.predicted_taken = 1'b1;
      queue_transfer(item, 1'b1);

      // Trap always with both operand sources; other trap conditions are unsupported.
      item = '0;
      item.action = sbr_pkg::ACT_TICC;
      item.cond = sbr_pkg::COND_ALWAYS;
      item.use_immediate = 1'b1;
      item.immediate = 30'h3FFF_FFFF;
      item.rs1_value = 32'h0000_007F;
      item.check_prediction = 1'b1;
      queue_transfer(item, 1'b0);
      item = '0;
      item.action = sbr_pkg::ACT_TICC;
      item.cond = sbr_pkg::COND_ALWAYS;
      item.rs1_value = 32'hFFFF_FFFF;
      item.rs2_value = 32'h0000_0080;
      item.pc = 32'hFFFF_FFF8;
      item.check_prediction = 1'b1;
      item.predicted_taken = 1'b1;
      queue_transfer(item, 1'b1);
      item = '0;
      item.action = sbr_pkg::ACT_TICC;
      item.cond = 4'd3;
      queue_transfer(item, 1'b0);
      item = '0;
      item.action = sbr_pkg::ACT_TICC;
      item.check_prediction = 1'b1;
      queue_transfer(item, 1'b0);
      wait_drained();

      // Random items under each mix of sender gaps and receiver stalls.
      run_random_phase(250, 0, 0);
      run_random_phase(200, 49, 0);
      run_random_phase(200, 0, 49);
      run_random_phase(200, 26, 26);

      // Long receiver hold-off while the sender keeps offering items.
      pressure_req = 1'b1;
      run_random_phase(250, 0, 10);

      repeat (6) @(posedge clock);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### sim.f
sv/sbr_pkg.sv
sv/sparc_branch_resolve_core.sv
tb/sv/tb.sv
